@@ sv/rcrq_pkg.sv @@
// shared types and constants for the reserve/commit ring queue
package rcrq_pkg;

  // command codes as they arrive, plus the class given to unknown codes
  typedef enum logic [2:0] {
    CMD_RESERVE = 3'd0,
    CMD_COMMIT  = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_DEQUEUE = 3'd3,
    CMD_FLUSH   = 3'd4,
    CMD_NOP     = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_WAIT     = 3'd2,
    ST_FLUSHED  = 3'd3,
    ST_RELEASED = 3'd4
  } status_t;

  // per-slot mark
  typedef enum logic [1:0] {
    MARK_EMPTY     = 2'd0,
    MARK_COMMITTED = 2'd1,
    MARK_RELEASED  = 2'd2
  } mark_t;

  // back end sequencer states
  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_DEQ  = 1'b1
  } back_state_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] slot;
  } req_t;

  localparam int unsigned SLOT_IDX_W   = 4;
  localparam int unsigned RELOAD_W     = 16;
  localparam logic [15:0] FLUSH_RELOAD_RESET = 16'd16;

endpackage

@@ sv/reserve_commit_ring_queue.sv @@
// reserve/commit ring queue: front request queue feeding the ring execution back end
// a result word is registered when its request leaves the front queue; a dequeue
// that consumes a slot adds BK_DEQ (registered read of the payload ram at the head)
// throughput: one word per cycle unless stalled by out_ready or by the BK_DEQ state
// reset: pointers zero, all marks empty, flush counter and reload 16; the payload
// ram is not cleared
module reserve_commit_ring_queue #(
  parameter int SLOTS         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                command,
  input  logic [3:0]                slot_index,
  input  logic [PAYLOAD_WIDTH-1:0]  payload_in,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [3:0]                slot_out,
  output logic [PAYLOAD_WIDTH-1:0]  payload_out
);

  logic                       q_valid;
  logic                       q_pop;
  rcrq_pkg::req_t             q_req;
  logic [PAYLOAD_WIDTH-1:0]   q_payload;

  // input side
  rcrq_front #(
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .slot_index (slot_index),
    .payload_in (payload_in),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_req      (q_req),
    .q_payload  (q_payload)
  );

  // ring execution and output word
  rcrq_back #(
    .SLOTS        (SLOTS),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_req       (q_req),
    .q_payload   (q_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_out    (slot_out),
    .payload_out (payload_out)
  );

endmodule

@@ sv/rcrq_front.sv @@
// front end: accepts input words, classifies the command and queues requests
module rcrq_front #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                command,
  input  logic [3:0]                slot_index,
  input  logic [PAYLOAD_WIDTH-1:0]  payload_in,
  output logic                      q_valid,
  input  logic                      q_pop,
  output rcrq_pkg::req_t            q_req,
  output logic [PAYLOAD_WIDTH-1:0]  q_payload
);

  rcrq_pkg::req_t             req_mem [2];
  logic [PAYLOAD_WIDTH-1:0]   pay_mem [2];
  logic                       wptr;
  logic                       rptr;
  logic [1:0]                 count;
  logic                       push;
  rcrq_pkg::req_t             cls;

  // classify the incoming command; unknown codes become a no-op
  always_comb begin
    cls.slot = slot_index;
    case (command)
      rcrq_pkg::CMD_RESERVE,
      rcrq_pkg::CMD_COMMIT,
      rcrq_pkg::CMD_RELEASE,
      rcrq_pkg::CMD_DEQUEUE,
      rcrq_pkg::CMD_FLUSH: cls.cmd = rcrq_pkg::cmd_t'(command);
      default:             cls.cmd = rcrq_pkg::CMD_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (count != 2'd0);
  assign q_req     = req_mem[rptr];
  assign q_payload = pay_mem[rptr];

  // two-entry request queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      req_mem[wptr] <= cls;
      pay_mem[wptr] <= payload_in;
    end
  end

endmodule

@@ sv/rcrq_back.sv @@
// back end: executes queued requests against the ring and drives the result word
module rcrq_back #(
  parameter int SLOTS         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  rcrq_pkg::req_t            q_req,
  input  logic [PAYLOAD_WIDTH-1:0]  q_payload,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [3:0]                slot_out,
  output logic [PAYLOAD_WIDTH-1:0]  payload_out
);

  localparam int PW = $clog2(SLOTS);

  rcrq_pkg::back_state_t      state, state_next;
  logic [PW-1:0]              head, head_next;
  logic [PW-1:0]              tail, tail_next;
  logic [15:0]                counter, counter_next;
  logic [15:0]                reload, reload_next;
  rcrq_pkg::mark_t            marks [SLOTS];
  rcrq_pkg::mark_t            marks_next [SLOTS];
  logic [PAYLOAD_WIDTH-1:0]   mem [SLOTS];
  logic [PAYLOAD_WIDTH-1:0]   rdata;
  logic                       mem_we;
  logic [PW-1:0]              idx;

  logic                       ov_next;
  rcrq_pkg::status_t          ostat, ostat_next;
  logic [3:0]                 oslot, oslot_next;
  logic [PAYLOAD_WIDTH-1:0]   opay, opay_next;

  rcrq_pkg::status_t          dq_status, dq_status_next;
  logic [3:0]                 dq_slot, dq_slot_next;
  logic                       dq_commit, dq_commit_next;

  logic                       out_free;
  logic                       have;

  assign idx      = PW'(q_req.slot);
  assign out_free = !out_valid || out_ready;
  assign have     = (head != tail) && (marks[head] != rcrq_pkg::MARK_EMPTY);

  // next state and result selection
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    counter_next   = counter;
    reload_next    = reload;
    marks_next     = marks;
    mem_we         = 1'b0;
    q_pop          = 1'b0;
    ov_next        = out_valid && !out_ready;
    ostat_next     = ostat;
    oslot_next     = oslot;
    opay_next      = opay;
    dq_status_next = dq_status;
    dq_slot_next   = dq_slot;
    dq_commit_next = dq_commit;
    case (state)
      rcrq_pkg::BK_EXEC: begin
        if (q_valid && out_free) begin
          q_pop      = 1'b1;
          ov_next    = 1'b1;
          ostat_next = rcrq_pkg::ST_OK;
          oslot_next = '0;
          opay_next  = '0;
          case (q_req.cmd)
            rcrq_pkg::CMD_RESERVE: begin
              if (tail + PW'(1) == head) begin
                ostat_next = rcrq_pkg::ST_FULL;
              end else begin
                oslot_next = 4'(tail);
                tail_next  = tail + PW'(1);
              end
            end
            rcrq_pkg::CMD_COMMIT: begin
              mem_we          = 1'b1;
              marks_next[idx] = rcrq_pkg::MARK_COMMITTED;
              oslot_next      = 4'(idx);
            end
            rcrq_pkg::CMD_RELEASE: begin
              marks_next[idx] = rcrq_pkg::MARK_RELEASED;
              oslot_next      = 4'(idx);
            end
            rcrq_pkg::CMD_DEQUEUE: begin
              if (counter != 16'd0 && !have) begin
                ostat_next = rcrq_pkg::ST_WAIT;
              end else begin
                // step the flush counter
                if (counter == 16'd0) counter_next = reload;
                else counter_next = counter - 16'd1;
                if (!have) begin
                  ostat_next = rcrq_pkg::ST_FLUSHED;
                end else begin
                  // consume head slot; payload arrives from the ram next cycle
                  ov_next          = 1'b0;
                  state_next       = rcrq_pkg::BK_DEQ;
                  dq_slot_next     = 4'(head);
                  dq_commit_next   = (marks[head] == rcrq_pkg::MARK_COMMITTED);
                  dq_status_next   = dq_commit_next ? rcrq_pkg::ST_OK
                                                    : rcrq_pkg::ST_RELEASED;
                  marks_next[head] = rcrq_pkg::MARK_EMPTY;
                  head_next        = head + PW'(1);
                end
              end
            end
            rcrq_pkg::CMD_FLUSH: begin
              counter_next = 16'd0;
            end
            default: begin
            end
          endcase
        end
      end
      rcrq_pkg::BK_DEQ: begin
        if (out_free) begin
          ov_next    = 1'b1;
          ostat_next = dq_status;
          oslot_next = dq_slot;
          opay_next  = dq_commit ? rdata : '0;
          state_next = rcrq_pkg::BK_EXEC;
        end
      end
      default: begin
        state_next = rcrq_pkg::BK_EXEC;
      end
    endcase
    // register write also loads the counter
    if (cfg_wr_en) begin
      reload_next  = cfg_wr_data;
      counter_next = cfg_wr_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcrq_pkg::BK_EXEC;
      head      <= '0;
      tail      <= '0;
      counter   <= rcrq_pkg::FLUSH_RELOAD_RESET;
      reload    <= rcrq_pkg::FLUSH_RELOAD_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) marks[i] <= rcrq_pkg::MARK_EMPTY;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      counter   <= counter_next;
      reload    <= reload_next;
      out_valid <= ov_next;
      marks     <= marks_next;
    end
  end

  // result word and pending dequeue registers
  always_ff @(posedge clk) begin
    ostat     <= ostat_next;
    oslot     <= oslot_next;
    opay      <= opay_next;
    dq_status <= dq_status_next;
    dq_slot   <= dq_slot_next;
    dq_commit <= dq_commit_next;
  end

  // payload ram: write on commit, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= q_payload;
    rdata <= mem[head];
  end

  assign status      = ostat;
  assign slot_out    = oslot;
  assign payload_out = opay;

endmodule
